// ----- rtl/core/scr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the SCSI controller register model.
// No dependencies; used by scr_ctrl, scr_dp and the top level.
package scr_pkg;

    // Default build sizes
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int CMD_LEN_DEF    = 12;
    localparam int REG_COUNT      = 16;

    // Field widths
    localparam int FUNC_W = 3;
    localparam int OFF_W  = 4;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 24;
    localparam int ID_W   = 3;
    localparam int PH_W   = 4;
    localparam int DLY_W  = 16;
    localparam int CFGI_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ    = 3'd0,
        FUNC_WRITE   = 3'd1,
        FUNC_TICK    = 3'd2,
        FUNC_DMA_IN  = 3'd3,
        FUNC_DMA_OUT = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SEND = 2'd2
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic send;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic burst;
        logic burst_end;
    } t_status;

    // Register map
    localparam logic [OFF_W-1:0] REG_CNT_LO   = 4'd0;
    localparam logic [OFF_W-1:0] REG_CNT_MID  = 4'd1;
    localparam logic [OFF_W-1:0] REG_FIFO     = 4'd2;
    localparam logic [OFF_W-1:0] REG_CMD      = 4'd3;
    localparam logic [OFF_W-1:0] REG_STATUS   = 4'd4;
    localparam logic [OFF_W-1:0] REG_IRQ      = 4'd5;
    localparam logic [OFF_W-1:0] REG_SEQ      = 4'd6;
    localparam logic [OFF_W-1:0] REG_FLAGS    = 4'd7;
    localparam logic [OFF_W-1:0] REG_CNT_HI   = 4'd14;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_TGT_MASK = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_IRQ_DLY  = 2'd1;

    // Command codes (bit 7 is the DMA flag and is dropped)
    localparam logic [6:0] CMD_MASK      = 7'h7f;
    localparam logic [6:0] CMD_NOP       = 7'h00;
    localparam logic [6:0] CMD_RESET_DEV = 7'h02;
    localparam logic [6:0] CMD_RESET_BUS = 7'h03;
    localparam logic [6:0] CMD_SEL_ATN   = 7'h42;
    localparam logic [6:0] CMD_EN_SEL    = 7'h44;
    localparam logic [6:0] CMD_XFER_INFO = 7'h10;
    localparam logic [6:0] CMD_XFER_DONE = 7'h11;
    localparam logic [6:0] CMD_MSG_ACC   = 7'h12;

    // First CDB bytes that finish selection in one sequence step
    localparam logic [BYTE_W-1:0] OPC_TEST_READY = 8'h00;
    localparam logic [BYTE_W-1:0] OPC_SHORT_A    = 8'h48;
    localparam logic [BYTE_W-1:0] OPC_SHORT_B    = 8'h4b;

    // Register values and status bits
    localparam logic [BYTE_W-1:0] IRQ_SVC_REQ = 8'h08;
    localparam logic [BYTE_W-1:0] SEQ_STEP_4  = 8'h04;
    localparam logic [BYTE_W-1:0] SEQ_STEP_6  = 8'h06;
    localparam int STAT_IRQ_BIT = 7;
    localparam int STAT_CNT_BIT = 4;
    localparam logic [PH_W-1:0] PHASE_MAX = 4'd10;

    // Transfer-phase counter to low status bits
    function automatic logic [2:0] phase_bits(input logic [PH_W-1:0] p);
        logic [2:0] b;
        case (p)
            4'd2, 4'd3: b = 3'd1;
            4'd4:       b = 3'd2;
            4'd5:       b = 3'd3;
            4'd6:       b = 3'd4;
            4'd7:       b = 3'd5;
            4'd8:       b = 3'd6;
            4'd9:       b = 3'd7;
            default:    b = 3'd0;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/scr_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: accept, execute, command-byte burst.
// Depends on scr_pkg.
module scr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  scr_pkg::t_status i_status,
    output scr_pkg::t_cmd    o_cmd
);

    scr_pkg::t_state r_state;
    scr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            scr_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
                if (start) begin
                    n_state = scr_pkg::ST_EXEC;
                end
            end
            scr_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.burst ? scr_pkg::ST_SEND : scr_pkg::ST_IDLE;
            end
            scr_pkg::ST_SEND: begin
                o_cmd.send = 1'b1;
                if (i_status.burst_end) begin
                    n_state = scr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/scr_dp.sv -----
`timescale 1ns / 1ps
// Datapath: register mirror, command FIFO, timers, config and result registers.
// Depends on scr_pkg.
module scr_dp #(
    parameter int FIFO_DEPTH = scr_pkg::FIFO_DEPTH_DEF,
    parameter int CMD_LEN    = scr_pkg::CMD_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scr_pkg::t_cmd               i_cmd,
    output scr_pkg::t_status            o_status,
    input  logic [scr_pkg::FUNC_W-1:0]  i_func,
    input  logic [scr_pkg::OFF_W-1:0]   i_reg_offset,
    input  logic [scr_pkg::BYTE_W-1:0]  i_wr_data,
    input  logic [scr_pkg::LEN_W-1:0]   i_dma_length,
    input  logic                        i_cfg_we,
    input  logic [scr_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [scr_pkg::DLY_W-1:0]   i_cfg_data,
    output logic                        o_strobe,
    output logic [scr_pkg::BYTE_W-1:0]  o_rd_data,
    output logic                        o_irq_raise,
    output logic                        o_target_reset,
    output logic                        o_cmd_byte_valid,
    output logic [scr_pkg::BYTE_W-1:0]  o_cmd_byte,
    output logic                        o_dma_start,
    output logic                        o_dma_to_target,
    output logic [scr_pkg::LEN_W-1:0]   o_dma_count,
    output logic [scr_pkg::ID_W-1:0]    o_target_id,
    output logic                        o_bad_command,
    output logic                        o_last
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int KW = $clog2(CMD_LEN + 1);

    // Latched transaction
    scr_pkg::t_func              r_func;
    logic [scr_pkg::OFF_W-1:0]   r_off;
    logic [scr_pkg::BYTE_W-1:0]  r_data;
    logic [scr_pkg::LEN_W-1:0]   r_len;

    // Config
    logic [scr_pkg::BYTE_W-1:0]  r_tgt_mask;
    logic [scr_pkg::DLY_W-1:0]   r_irq_dly;

    // Model state
    logic [scr_pkg::BYTE_W-1:0]  r_mirror [scr_pkg::REG_COUNT];
    logic [scr_pkg::BYTE_W-1:0]  n_mirror [scr_pkg::REG_COUNT];
    logic [AW-1:0]               r_ptr, n_ptr;
    logic [scr_pkg::PH_W-1:0]    r_phase, n_phase;
    logic [scr_pkg::ID_W-1:0]    r_sel, n_sel;
    logic [scr_pkg::DLY_W-1:0]   r_dcnt, n_dcnt;
    logic                        r_armed, n_armed;

    // FIFO memory with per-entry valid bits (unwritten slots read as zero)
    logic [scr_pkg::BYTE_W-1:0]  r_fifo [FIFO_DEPTH];
    logic [FIFO_DEPTH-1:0]       r_fifo_vld;
    logic [scr_pkg::BYTE_W-1:0]  r_mem_q;
    logic                        r_mem_vld;
    logic [AW-1:0]               rd_addr;
    logic                        fifo_we;
    logic [scr_pkg::BYTE_W-1:0]  fifo_q;

    // Burst counter
    logic [KW-1:0]               r_k;

    // Result
    logic [scr_pkg::BYTE_W-1:0]  n_rd;
    logic                        n_irq, n_trst, n_dstart, n_bad, burst;

    logic                        here;
    logic [6:0]                  cmd_code;

    assign here     = r_tgt_mask[r_sel];
    assign cmd_code = r_data[6:0] & scr_pkg::CMD_MASK;
    assign fifo_q   = r_mem_vld ? r_mem_q : '0;

    assign burst = (r_func == scr_pkg::FUNC_WRITE) && (r_off == scr_pkg::REG_CMD)
                   && (cmd_code == scr_pkg::CMD_SEL_ATN) && here;
    assign o_status.burst     = burst;
    assign o_status.burst_end = (r_k == KW'(CMD_LEN - 1));

    // Read address: slot 1 at accept, slot 2 at execute, then one ahead
    always_comb begin
        if (i_cmd.load) begin
            rd_addr = AW'(1);
        end else if (i_cmd.exec) begin
            rd_addr = AW'(2);
        end else begin
            rd_addr = AW'(r_k) + AW'(2);
        end
    end

    assign fifo_we = i_cmd.exec && (r_func == scr_pkg::FUNC_WRITE)
                     && (r_off == scr_pkg::REG_FIFO);

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo[r_ptr] <= r_data;
        end
        r_mem_q <= r_fifo[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_vld <= '0;
            r_mem_vld  <= 1'b0;
        end else begin
            if (fifo_we) begin
                r_fifo_vld[r_ptr] <= 1'b1;
            end
            r_mem_vld <= r_fifo_vld[rd_addr];
        end
    end

    // Next state of one transaction, in model order
    always_comb begin
        logic [scr_pkg::PH_W-1:0] p;
        logic [scr_pkg::DLY_W-1:0] dec;
        n_mirror = r_mirror;
        n_ptr    = r_ptr;
        n_phase  = r_phase;
        n_sel    = r_sel;
        n_dcnt   = r_dcnt;
        n_armed  = r_armed;
        n_rd     = '0;
        n_irq    = 1'b0;
        n_trst   = 1'b0;
        n_dstart = 1'b0;
        n_bad    = 1'b0;
        p        = (r_phase <= scr_pkg::PHASE_MAX) ? r_phase : scr_pkg::PHASE_MAX;
        dec      = (r_dcnt != '0) ? r_dcnt - DLY_W1() : r_dcnt;
        case (r_func)
            scr_pkg::FUNC_READ: begin
                if (r_off == scr_pkg::REG_STATUS) begin
                    n_mirror[scr_pkg::REG_STATUS][2:0] = scr_pkg::phase_bits(p);
                    n_phase = (p < scr_pkg::PHASE_MAX) ? p + 4'd1 : p;
                end
                n_rd = n_mirror[r_off];
                if (r_off == scr_pkg::REG_FIFO) begin
                    n_rd = '0;
                end else if (r_off == scr_pkg::REG_IRQ) begin
                    n_mirror[scr_pkg::REG_STATUS][scr_pkg::STAT_IRQ_BIT] = 1'b0;
                end
            end
            scr_pkg::FUNC_WRITE: begin
                if (r_off == scr_pkg::REG_STATUS) begin
                    n_sel = r_data[scr_pkg::ID_W-1:0];
                end
                if (r_off == scr_pkg::REG_CNT_LO || r_off == scr_pkg::REG_CNT_MID
                    || r_off == scr_pkg::REG_CNT_HI) begin
                    n_mirror[scr_pkg::REG_STATUS][scr_pkg::STAT_CNT_BIT] = 1'b0;
                end
                if (r_off == scr_pkg::REG_FIFO) begin
                    n_ptr = (r_ptr == AW'(FIFO_DEPTH - 1)) ? r_ptr : r_ptr + AW'(1);
                end
                if (r_off == scr_pkg::REG_CMD) begin
                    n_ptr = '0;
                    unique case (cmd_code) inside
                        scr_pkg::CMD_NOP: begin
                            n_mirror[scr_pkg::REG_IRQ] = scr_pkg::IRQ_SVC_REQ;
                            n_phase = '0;
                        end
                        scr_pkg::CMD_RESET_DEV: begin
                            n_mirror[scr_pkg::REG_IRQ] = scr_pkg::IRQ_SVC_REQ;
                            n_trst  = here;
                            n_phase = '0;
                        end
                        scr_pkg::CMD_RESET_BUS: begin
                            n_mirror[scr_pkg::REG_SEQ] = scr_pkg::SEQ_STEP_4;
                            n_phase = '0;
                            n_dcnt  = r_irq_dly;
                            n_armed = 1'b1;
                        end
                        scr_pkg::CMD_SEL_ATN: begin
                            n_dcnt  = r_irq_dly;
                            n_armed = 1'b1;
                            n_mirror[scr_pkg::REG_SEQ] =
                                (fifo_q == scr_pkg::OPC_TEST_READY
                                 || fifo_q == scr_pkg::OPC_SHORT_A
                                 || fifo_q == scr_pkg::OPC_SHORT_B)
                                ? scr_pkg::SEQ_STEP_6 : scr_pkg::SEQ_STEP_4;
                            n_phase = '0;
                        end
                        scr_pkg::CMD_EN_SEL: begin
                            n_phase = '0;
                        end
                        scr_pkg::CMD_XFER_INFO, scr_pkg::CMD_XFER_DONE,
                        scr_pkg::CMD_MSG_ACC: begin
                            n_dcnt  = r_irq_dly;
                            n_armed = 1'b1;
                            n_mirror[scr_pkg::REG_SEQ] = scr_pkg::SEQ_STEP_6;
                        end
                        default: begin
                            n_bad = 1'b1;
                        end
                    endcase
                end
                if (r_off != scr_pkg::REG_STATUS && r_off != scr_pkg::REG_IRQ
                    && r_off != scr_pkg::REG_SEQ && r_off != scr_pkg::REG_FLAGS) begin
                    n_mirror[r_off] = r_data;
                end
            end
            scr_pkg::FUNC_TICK: begin
                if (r_armed) begin
                    n_dcnt = dec;
                    if (dec == '0) begin
                        n_armed = 1'b0;
                        n_mirror[scr_pkg::REG_IRQ] = scr_pkg::IRQ_SVC_REQ;
                        n_mirror[scr_pkg::REG_STATUS][scr_pkg::STAT_IRQ_BIT] = 1'b1;
                        n_irq = 1'b1;
                    end
                end
            end
            scr_pkg::FUNC_DMA_IN, scr_pkg::FUNC_DMA_OUT: begin
                n_mirror[scr_pkg::REG_STATUS][scr_pkg::STAT_CNT_BIT] = 1'b1;
                n_dstart = here;
            end
            default: begin
            end
        endcase
    end

    function automatic logic [scr_pkg::DLY_W-1:0] DLY_W1();
        return {{(scr_pkg::DLY_W-1){1'b0}}, 1'b1};
    endfunction

    // Latch, config and state registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= scr_pkg::t_func'(i_func);
            r_off  <= i_reg_offset;
            r_data <= i_wr_data;
            r_len  <= i_dma_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_mask <= '0;
            r_irq_dly  <= DLY_W1();
            r_ptr      <= '0;
            r_phase    <= '0;
            r_sel      <= '0;
            r_dcnt     <= '0;
            r_armed    <= 1'b0;
            r_k        <= '0;
            for (int i = 0; i < scr_pkg::REG_COUNT; i++) begin
                r_mirror[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    scr_pkg::CFG_TGT_MASK: r_tgt_mask <= i_cfg_data[scr_pkg::BYTE_W-1:0];
                    scr_pkg::CFG_IRQ_DLY:  r_irq_dly  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_mirror <= n_mirror;
                r_ptr    <= n_ptr;
                r_phase  <= n_phase;
                r_sel    <= n_sel;
                r_dcnt   <= n_dcnt;
                r_armed  <= n_armed;
                r_k      <= KW'(1);
            end else if (i_cmd.send) begin
                r_k <= r_k + KW'(1);
            end
        end
    end

    // Result registers and the o_strobe flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.exec || i_cmd.send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_target_id      <= r_sel;
            o_rd_data        <= burst ? '0 : n_rd;
            o_irq_raise      <= n_irq;
            o_target_reset   <= n_trst;
            o_cmd_byte_valid <= burst;
            o_cmd_byte       <= burst ? fifo_q : '0;
            o_dma_start      <= n_dstart;
            o_dma_to_target  <= n_dstart && (r_func == scr_pkg::FUNC_DMA_OUT);
            o_dma_count      <= n_dstart ? r_len : '0;
            o_bad_command    <= n_bad;
            o_last           <= !burst;
        end else if (i_cmd.send) begin
            o_rd_data        <= '0;
            o_irq_raise      <= 1'b0;
            o_target_reset   <= 1'b0;
            o_cmd_byte_valid <= 1'b1;
            o_cmd_byte       <= fifo_q;
            o_dma_start      <= 1'b0;
            o_dma_to_target  <= 1'b0;
            o_dma_count      <= '0;
            o_bad_command    <= 1'b0;
            o_last           <= o_status.burst_end;
        end
    end

endmodule

// ----- rtl/core/scsi_controller_register_model_unit.sv -----
`timescale 1ns / 1ps
// Top level of the SCSI-2 controller register model.
// Depends on scr_pkg, scr_ctrl and scr_dp.
//
// A transaction is taken when start is high and busy is low. Results come
// out one per cycle, each flagged by o_strobe for exactly one cycle, and the
// receiver cannot stall them, so every result must be captured on the cycle
// it is shown. Most transactions (reads, writes, ticks, DMA requests) give a
// single result, registered after the execute state, and busy drops in the
// cycle the result appears, so a new transaction can be started then. A
// select-with-ATN command to a present target instead gives CMD_LEN results,
// the command bytes from FIFO slots 1 to CMD_LEN, on consecutive cycles; the
// FIFO is a single-read-port memory, read one slot ahead of the byte sent.
// o_last marks the final result of each transaction. No clearing pass is
// needed after reset.
//
// The configuration channel is always ready. Index 0 is the target-present
// mask (bit n for SCSI ID n), index 1 the interrupt delay in ticks; other
// indexes are ignored. Write configuration only while the block is idle.
module scsi_controller_register_model_unit #(
    parameter int FIFO_DEPTH = scr_pkg::FIFO_DEPTH_DEF,  // 16..64
    parameter int CMD_LEN    = scr_pkg::CMD_LEN_DEF      // 6..15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [scr_pkg::FUNC_W-1:0]  i_func,
    input  logic [scr_pkg::OFF_W-1:0]   i_reg_offset,
    input  logic [scr_pkg::BYTE_W-1:0]  i_wr_data,
    input  logic [scr_pkg::LEN_W-1:0]   i_dma_length,
    // Configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scr_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [scr_pkg::DLY_W-1:0]   i_cfg_data,
    // Results
    output logic                        o_strobe,
    output logic [scr_pkg::BYTE_W-1:0]  o_rd_data,
    output logic                        o_irq_raise,
    output logic                        o_target_reset,
    output logic                        o_cmd_byte_valid,
    output logic [scr_pkg::BYTE_W-1:0]  o_cmd_byte,
    output logic                        o_dma_start,
    output logic                        o_dma_to_target,
    output logic [scr_pkg::LEN_W-1:0]   o_dma_count,
    output logic [scr_pkg::ID_W-1:0]    o_target_id,
    output logic                        o_bad_command,
    output logic                        o_last
);

    scr_pkg::t_cmd    cmd;
    scr_pkg::t_status status;

    // Config is plain register writes: never back-pressured
    assign o_cfg_ready = 1'b1;

    // Sequencer: idle / execute / command-byte burst
    scr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Mirror, FIFO, timers and result registers
    scr_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CMD_LEN    (CMD_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_func           (i_func),
        .i_reg_offset     (i_reg_offset),
        .i_wr_data        (i_wr_data),
        .i_dma_length     (i_dma_length),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_rd_data        (o_rd_data),
        .o_irq_raise      (o_irq_raise),
        .o_target_reset   (o_target_reset),
        .o_cmd_byte_valid (o_cmd_byte_valid),
        .o_cmd_byte       (o_cmd_byte),
        .o_dma_start      (o_dma_start),
        .o_dma_to_target  (o_dma_to_target),
        .o_dma_count      (o_dma_count),
        .o_target_id      (o_target_id),
        .o_bad_command    (o_bad_command),
        .o_last           (o_last)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for scsi_controller_register_model_unit.
// Depends on scr_pkg and the RTL only; results are predicted in-line or typed in the table.
module tb;
    import scr_pkg::*;

    // Unused function codes: the block must answer them with a plain result
    localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED       = 3'd7;
    // A command byte that no decoder entry matches
    localparam logic [BYTE_W-1:0] CMD_UNSUPPORTED   = 8'h7f;
    localparam int FIFO_DEPTH = FIFO_DEPTH_DEF;
    localparam int CMD_LEN    = CMD_LEN_DEF;

    // One result transaction as seen on the output ports
    typedef struct packed {
        logic [BYTE_W-1:0] rd_data;
        logic              irq_raise;
        logic              target_reset;
        logic              cmd_byte_valid;
        logic [BYTE_W-1:0] cmd_byte;
        logic              dma_start;
        logic              dma_to_target;
        logic [LEN_W-1:0]  dma_count;
        logic [ID_W-1:0]   target_id;
        logic              bad_command;
        logic              last;
    } res_t;

    // One row of the directed table; 'typed' rows carry their result inline
    typedef struct {
        logic [FUNC_W-1:0] f;
        logic [OFF_W-1:0]  off;
        logic [BYTE_W-1:0] d;
        logic [LEN_W-1:0]  len;
        bit                typed;
        res_t              want;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func       = '0;
    logic [OFF_W-1:0]     i_reg_offset = '0;
    logic [BYTE_W-1:0]    i_wr_data    = '0;
    logic [LEN_W-1:0]     i_dma_length = '0;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFGI_W-1:0]    i_cfg_index  = '0;
    logic [DLY_W-1:0]     i_cfg_data   = '0;
    logic                 o_strobe;
    logic [BYTE_W-1:0]    o_rd_data;
    logic                 o_irq_raise;
    logic                 o_target_reset;
    logic                 o_cmd_byte_valid;
    logic [BYTE_W-1:0]    o_cmd_byte;
    logic                 o_dma_start;
    logic                 o_dma_to_target;
    logic [LEN_W-1:0]     o_dma_count;
    logic [ID_W-1:0]      o_target_id;
    logic                 o_bad_command;
    logic                 o_last;

    // Predictor state: the register mirror, command FIFO, phase counter,
    // selected target and interrupt timer, plus the two config registers
    logic [BYTE_W-1:0]    mirror_regs [REG_COUNT];
    logic [BYTE_W-1:0]    cmd_fifo [FIFO_DEPTH];
    int                   fifo_wr_ptr;
    logic [PH_W-1:0]      phase_ctr;
    logic [ID_W-1:0]      sel_id;
    logic [DLY_W-1:0]     irq_countdown;
    logic                 irq_armed;
    logic [7:0]           cfg_present;
    logic [DLY_W-1:0]     cfg_delay;
    logic [2:0]           phase_status_bits [11] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3,
                                                     3'd4, 3'd5, 3'd6, 3'd7, 3'd0};
    logic [6:0]           cmd_codes [8] = '{CMD_NOP, CMD_RESET_DEV, CMD_RESET_BUS,
                                            CMD_SEL_ATN, CMD_EN_SEL, CMD_XFER_INFO,
                                            CMD_XFER_DONE, CMD_MSG_ACC};

    res_t                 step_results [$];     // results of the access just predicted
    res_t                 pending_results [$];  // predicted, not yet seen on the ports
    stim_row_t            directed_rows [$];
    int                   fail_count = 0;
    int                   items_sent = 0;
    int                   idle_pct   = 0;       // sender hold-off chance per transaction

    scsi_controller_register_model_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_reg_offset     (i_reg_offset),
        .i_wr_data        (i_wr_data),
        .i_dma_length     (i_dma_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_rd_data        (o_rd_data),
        .o_irq_raise      (o_irq_raise),
        .o_target_reset   (o_target_reset),
        .o_cmd_byte_valid (o_cmd_byte_valid),
        .o_cmd_byte       (o_cmd_byte),
        .o_dma_start      (o_dma_start),
        .o_dma_to_target  (o_dma_to_target),
        .o_dma_count      (o_dma_count),
        .o_target_id      (o_target_id),
        .o_bad_command    (o_bad_command),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic string fmt(input res_t r);
        return $sformatf({"rd=%02h irq=%0b trst=%0b cmd=%0b/%02h dma=%0b dir=%0b ",
                          "cnt=%06h id=%0d bad=%0b last=%0b"},
                         r.rd_data, r.irq_raise, r.target_reset, r.cmd_byte_valid,
                         r.cmd_byte, r.dma_start, r.dma_to_target, r.dma_count,
                         r.target_id, r.bad_command, r.last);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    function automatic void arm_irq_timer();
        irq_countdown = cfg_delay;
        irq_armed     = 1'b1;
    endfunction

    // Predict the results of one accepted transaction into step_results and
    // move the predictor state on. Every transaction yields at least one result.
    function automatic void predict_access(input logic [FUNC_W-1:0] f,
                                           input logic [OFF_W-1:0] off,
                                           input logic [BYTE_W-1:0] d,
                                           input logic [LEN_W-1:0] len);
        res_t r;
        res_t b;
        bit   burst;
        logic [BYTE_W-1:0] first_cdb;
        step_results.delete();
        r = '0;
        r.target_id = sel_id;   // id as it stood before this access
        burst = 1'b0;
        case (f)
            FUNC_READ: begin
                if (off == REG_STATUS) begin
                    // phase counter feeds the low status bits and sticks at its top
                    mirror_regs[REG_STATUS][2:0] = phase_status_bits[phase_ctr];
                    if (phase_ctr < PHASE_MAX)
                        phase_ctr++;
                end
                r.rd_data = (off == REG_FIFO) ? '0 : mirror_regs[off];
                if (off == REG_IRQ)
                    mirror_regs[REG_STATUS][STAT_IRQ_BIT] = 1'b0;
            end
            FUNC_WRITE: begin
                if (off == REG_STATUS)
                    sel_id = d[ID_W-1:0];
                if (off == REG_CNT_LO || off == REG_CNT_MID || off == REG_CNT_HI)
                    mirror_regs[REG_STATUS][STAT_CNT_BIT] = 1'b0;
                if (off == REG_FIFO) begin
                    // saturating pointer: an overrun keeps hitting the last slot
                    cmd_fifo[fifo_wr_ptr] = d;
                    if (fifo_wr_ptr < FIFO_DEPTH - 1)
                        fifo_wr_ptr++;
                end
                if (off == REG_CMD) begin
                    fifo_wr_ptr = 0;
                    case (d[6:0])   // DMA flag in bit 7 plays no part
                        CMD_NOP: begin
                            mirror_regs[REG_IRQ] = IRQ_SVC_REQ;
                            phase_ctr = '0;
                        end
                        CMD_RESET_DEV: begin
                            mirror_regs[REG_IRQ] = IRQ_SVC_REQ;
                            r.target_reset = cfg_present[sel_id];
                            phase_ctr = '0;
                        end
                        CMD_RESET_BUS: begin
                            mirror_regs[REG_SEQ] = SEQ_STEP_4;
                            phase_ctr = '0;
                            arm_irq_timer();
                        end
                        CMD_SEL_ATN: begin
                            arm_irq_timer();
                            first_cdb = cmd_fifo[1];
                            mirror_regs[REG_SEQ] = (first_cdb == OPC_TEST_READY ||
                                                    first_cdb == OPC_SHORT_A ||
                                                    first_cdb == OPC_SHORT_B) ?
                                                   SEQ_STEP_6 : SEQ_STEP_4;
                            if (cfg_present[sel_id]) begin
                                burst = 1'b1;
                                for (int k = 0; k < CMD_LEN; k++) begin
                                    b = '0;
                                    b.target_id      = sel_id;
                                    b.cmd_byte_valid = 1'b1;
                                    b.cmd_byte       = cmd_fifo[(k + 1) % FIFO_DEPTH];
                                    b.last           = (k == CMD_LEN - 1);
                                    step_results.push_back(b);
                                end
                            end
                            phase_ctr = '0;
                        end
                        CMD_EN_SEL:
                            phase_ctr = '0;
                        CMD_XFER_INFO, CMD_XFER_DONE, CMD_MSG_ACC: begin
                            arm_irq_timer();
                            mirror_regs[REG_SEQ] = SEQ_STEP_6;
                        end
                        default:
                            r.bad_command = 1'b1;
                    endcase
                end
                if (off != REG_STATUS && off != REG_IRQ && off != REG_SEQ && off != REG_FLAGS)
                    mirror_regs[off] = d;
            end
            FUNC_TICK: begin
                if (irq_armed) begin
                    if (irq_countdown != '0)
                        irq_countdown--;
                    if (irq_countdown == '0) begin
                        irq_armed = 1'b0;
                        mirror_regs[REG_IRQ] = IRQ_SVC_REQ;
                        mirror_regs[REG_STATUS][STAT_IRQ_BIT] = 1'b1;
                        r.irq_raise = 1'b1;
                    end
                end
            end
            FUNC_DMA_IN, FUNC_DMA_OUT: begin
                mirror_regs[REG_STATUS][STAT_CNT_BIT] = 1'b1;
                if (cfg_present[sel_id]) begin
                    r.dma_start     = 1'b1;
                    r.dma_to_target = (f == FUNC_DMA_OUT);
                    r.dma_count     = len;
                end
            end
            default: ;
        endcase
        if (!burst) begin
            r.last = 1'b1;
            step_results.push_back(r);
        end
    endfunction

    // Drop start and let the sender sit idle; n sets the length of the pause
    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace();
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            hold_off($urandom_range(1, 16));
    endtask

    // Present one transaction and hold it until the block takes it. start is
    // left high so back-to-back transactions need no extra edge.
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [OFF_W-1:0] off,
                         input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
                         input bit typed, input res_t typed_res);
        start        <= 1'b1;
        i_func       <= f;
        i_reg_offset <= off;
        i_wr_data    <= d;
        i_dma_length <= len;
        do @(posedge i_clk); while (busy);
        predict_access(f, off, d, len);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        if (f <= FUNC_DMA_OUT)
            items_sent++;
    endtask

    task automatic send(input logic [FUNC_W-1:0] f, input logic [OFF_W-1:0] off,
                        input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len);
        pace();
        issue(f, off, d, len, 1'b0, '0);
    endtask

    // Wait until every predicted result has arrived and the block is idle;
    // gives up after a bounded wait so leftovers are reported, not hung on
    task automatic settle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((pending_results.size() != 0 || busy) && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Both config registers in one back-to-back burst on the config channel
    task automatic set_config(input logic [7:0] mask, input logic [DLY_W-1:0] dly);
        logic [7:0] junk;
        junk = $urandom;    // upper bits of the mask write are don't-care
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TGT_MASK;
        i_cfg_data  <= {junk, mask};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_present = mask;
        i_cfg_index <= CFG_IRQ_DLY;
        i_cfg_data  <= dly;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_delay = dly;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input logic [FUNC_W-1:0] f, input logic [OFF_W-1:0] off,
                                    input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len);
        stim_row_t row;
        row.f = f;
        row.off = off;
        row.d = d;
        row.len = len;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    // Row whose single result is written out by hand: read data, id, bad flag
    function automatic void add_typed(input logic [FUNC_W-1:0] f, input logic [OFF_W-1:0] off,
                                      input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
                                      input logic [BYTE_W-1:0] rd, input logic [ID_W-1:0] id,
                                      input logic bad);
        stim_row_t row;
        row.f = f;
        row.off = off;
        row.d = d;
        row.len = len;
        row.typed = 1'b1;
        row.want = '0;
        row.want.rd_data = rd;
        row.want.target_id = id;
        row.want.bad_command = bad;
        row.want.last = 1'b1;
        directed_rows.push_back(row);
    endfunction

    // One random burst of traffic. Most of it is well-formed: load CDB bytes,
    // select, tick the timer, poll status. The rest is random access and noise.
    task automatic random_group();
        int pick;
        int n;
        logic flag;
        logic [BYTE_W-1:0] cdb;
        logic [6:0] code;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        flag = $urandom_range(0, 1);
        if (pick < 18) begin
            // select sequence: pick target, fill FIFO (sometimes past full), select
            send(FUNC_WRITE, REG_STATUS, $urandom, $urandom);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(FIFO_DEPTH - 2, FIFO_DEPTH + 4)
                                            : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                cdb = $urandom;
                if (i == 1) begin
                    case ($urandom_range(0, 3))
                        0: cdb = OPC_TEST_READY;
                        1: cdb = OPC_SHORT_A;
                        2: cdb = OPC_SHORT_B;
                        default: ;
                    endcase
                end
                send(FUNC_WRITE, REG_FIFO, cdb, $urandom);
            end
            send(FUNC_WRITE, REG_CMD, {flag, CMD_SEL_ATN}, $urandom);
            repeat ($urandom_range(0, 3)) send(FUNC_TICK, $urandom, $urandom, $urandom);
        end else if (pick < 34) begin
            code = ($urandom_range(0, 8) == 8) ? 7'($urandom) : cmd_codes[$urandom_range(0, 7)];
            send(FUNC_WRITE, REG_CMD, {flag, code}, $urandom);
        end else if (pick < 48) begin
            repeat ($urandom_range(1, 4)) send(FUNC_TICK, $urandom, $urandom, $urandom);
        end else if (pick < 62) begin
            // status polling walks the phase counter up to its ceiling
            repeat ($urandom_range(1, 6)) send(FUNC_READ, REG_STATUS, $urandom, $urandom);
            if (flag)
                send(FUNC_READ, REG_IRQ, $urandom, $urandom);
        end else if (pick < 72) begin
            case ($urandom_range(0, 3))
                0: len = '0;
                1: len = '1;
                default: len = $urandom;
            endcase
            send(flag ? FUNC_DMA_OUT : FUNC_DMA_IN, $urandom, $urandom, len);
        end else if (pick < 90) begin
            send(flag ? FUNC_WRITE : FUNC_READ, $urandom, $urandom, $urandom);
        end else begin
            send($urandom_range(FUNC_FIRST_UNUSED, FUNC_UNUSED), $urandom, $urandom, $urandom);
        end
        // now and then let everything drain before carrying on
        if ($urandom_range(0, 39) == 0)
            settle();
    endtask

    // Result checker: the receiver cannot stall, so every strobe is compared
    // against the oldest outstanding prediction on the cycle it is shown.
    always @(posedge i_clk) begin
        res_t got;
        res_t want;
        if (i_rst_n && o_strobe) begin
            got.rd_data        = o_rd_data;
            got.irq_raise      = o_irq_raise;
            got.target_reset   = o_target_reset;
            got.cmd_byte_valid = o_cmd_byte_valid;
            got.cmd_byte       = o_cmd_byte;
            got.dma_start      = o_dma_start;
            got.dma_to_target  = o_dma_to_target;
            got.dma_count      = o_dma_count;
            got.target_id      = o_target_id;
            got.bad_command    = o_bad_command;
            got.last           = o_last;
            if (pending_results.size() == 0) begin
                note_failure({"unexpected result: ", fmt(got)});
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_failure({"expected ", fmt(want), " got ", fmt(got)});
            end
        end
    end

    initial begin
        logic [7:0] mask;
        logic [DLY_W-1:0] dly;
        int goal;

        // predictor matches the post-reset state
        foreach (mirror_regs[i]) mirror_regs[i] = '0;
        foreach (cmd_fifo[i]) cmd_fifo[i] = '0;
        fifo_wr_ptr   = 0;
        phase_ctr     = '0;
        sel_id        = '0;
        irq_countdown = '0;
        irq_armed     = 1'b0;
        cfg_present   = '0;
        cfg_delay     = 16'd1;

        // directed table: reset view, id select, FIFO + select with ATN,
        // every command branch, timer, DMA both ways, unused function, unstored regs
        add_typed(FUNC_READ,  REG_STATUS, 8'h00, 24'h0, 8'h00, 3'd0, 1'b0);
        add_typed(FUNC_READ,  REG_STATUS, 8'hff, 24'h0, 8'h00, 3'd0, 1'b0);
        add_typed(FUNC_READ,  REG_FIFO,   8'h00, 24'h0, 8'h00, 3'd0, 1'b0);
        // a write to status reports the id that stood before it
        add_typed(FUNC_WRITE, REG_STATUS, 8'hff, 24'h0, 8'h00, 3'd0, 1'b0);
        add_typed(FUNC_WRITE, REG_STATUS, 8'h05, 24'h0, 8'h00, 3'd7, 1'b0);
        add_row(FUNC_WRITE, REG_CNT_LO, 8'hff, 24'h0);
        add_row(FUNC_WRITE, REG_FIFO,   8'haa, 24'h0);
        add_row(FUNC_WRITE, REG_FIFO,   OPC_SHORT_B, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b0, CMD_SEL_ATN}, 24'h0);
        add_row(FUNC_TICK,  4'd0,       8'h00, 24'h0);
        add_row(FUNC_READ,  REG_IRQ,    8'h00, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b1, CMD_SEL_ATN}, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b0, CMD_NOP}, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b0, CMD_RESET_DEV}, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b0, CMD_RESET_BUS}, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b0, CMD_EN_SEL}, 24'h0);
        add_row(FUNC_WRITE, REG_CMD,    {1'b0, CMD_XFER_INFO}, 24'h0);
        add_typed(FUNC_WRITE, REG_CMD, CMD_UNSUPPORTED, 24'h0, 8'h00, 3'd5, 1'b1);
        add_row(FUNC_TICK,  4'd15,      8'hff, 24'hffffff);   // fires
        add_row(FUNC_TICK,  4'd0,       8'h00, 24'h0);        // not armed
        add_row(FUNC_DMA_IN,  4'd0,     8'h00, 24'hffffff);
        add_row(FUNC_DMA_OUT, 4'd15,    8'hff, 24'h000000);
        add_typed(FUNC_UNUSED, 4'd15, 8'hff, 24'hffffff, 8'h00, 3'd5, 1'b0);
        add_row(FUNC_WRITE, REG_FLAGS,  8'hff, 24'h0);        // not stored
        add_row(FUNC_READ,  REG_FLAGS,  8'h00, 24'h0);

        // synchronous reset held, then released once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(8'hff, 16'd1);
        idle_pct = 30;
        foreach (directed_rows[i]) begin
            pace();
            issue(directed_rows[i].f, directed_rows[i].off, directed_rows[i].d,
                  directed_rows[i].len, directed_rows[i].typed, directed_rows[i].want);
        end
        settle();

        // Random phases, each under its own configuration: no targets with a
        // zero delay, mixed, all targets with the longest delay, a single
        // target, and a final phase with the sender never pausing.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin mask = 8'h00; dly = 16'd0; idle_pct = 25; end
                1: begin mask = $urandom; dly = $urandom_range(1, 6); idle_pct = 50; end
                2: begin mask = 8'hff; dly = 16'hffff; idle_pct = 10; end
                3: begin mask = 8'h01 << $urandom_range(0, 7); dly = 16'd2; idle_pct = 30; end
                default: begin mask = $urandom; dly = $urandom_range(1, 4); idle_pct = 0; end
            endcase
            set_config(mask, dly);
            goal = items_sent + 40;
            while (items_sent < goal)
                random_group();
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
